### hdl/mx4_pkg.sv
// Shared types, constants and cofactor term tables for the 4x4 matrix inverter.
package mx4_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EL_W = 32;
	localparam int CMAG_W = 96;
	localparam int COF_W = 97;
	localparam int PMAG_W = 128;
	localparam int DMAG_W = 130;
	localparam int DET_W = 131;
	localparam int QB = 34;

	localparam logic BASE_SIGN [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

	localparam logic ROW_FLIP [16] = '{
		1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
		1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0
	};

	localparam logic [3:0] TERMS [16][6][3] = '{
		'{'{4'd5, 4'd10, 4'd15}, '{4'd5, 4'd11, 4'd14}, '{4'd9, 4'd6, 4'd15},
		  '{4'd9, 4'd7, 4'd14}, '{4'd13, 4'd6, 4'd11}, '{4'd13, 4'd7, 4'd10}},
		'{'{4'd1, 4'd10, 4'd15}, '{4'd1, 4'd11, 4'd14}, '{4'd9, 4'd2, 4'd15},
		  '{4'd9, 4'd3, 4'd14}, '{4'd13, 4'd2, 4'd11}, '{4'd13, 4'd3, 4'd10}},
		'{'{4'd1, 4'd6, 4'd15}, '{4'd1, 4'd7, 4'd14}, '{4'd5, 4'd2, 4'd15},
		  '{4'd5, 4'd3, 4'd14}, '{4'd13, 4'd2, 4'd7}, '{4'd13, 4'd3, 4'd6}},
		'{'{4'd1, 4'd6, 4'd11}, '{4'd1, 4'd7, 4'd10}, '{4'd5, 4'd2, 4'd11},
		  '{4'd5, 4'd3, 4'd10}, '{4'd9, 4'd2, 4'd7}, '{4'd9, 4'd3, 4'd6}},
		'{'{4'd4, 4'd10, 4'd15}, '{4'd4, 4'd11, 4'd14}, '{4'd8, 4'd6, 4'd15},
		  '{4'd8, 4'd7, 4'd14}, '{4'd12, 4'd6, 4'd11}, '{4'd12, 4'd7, 4'd10}},
		'{'{4'd0, 4'd10, 4'd15}, '{4'd0, 4'd11, 4'd14}, '{4'd8, 4'd2, 4'd15},
		  '{4'd8, 4'd3, 4'd14}, '{4'd12, 4'd2, 4'd11}, '{4'd12, 4'd3, 4'd10}},
		'{'{4'd0, 4'd6, 4'd15}, '{4'd0, 4'd7, 4'd14}, '{4'd4, 4'd2, 4'd15},
		  '{4'd4, 4'd3, 4'd14}, '{4'd12, 4'd2, 4'd7}, '{4'd12, 4'd3, 4'd6}},
		'{'{4'd0, 4'd6, 4'd11}, '{4'd0, 4'd7, 4'd10}, '{4'd4, 4'd2, 4'd11},
		  '{4'd4, 4'd3, 4'd10}, '{4'd8, 4'd2, 4'd7}, '{4'd8, 4'd3, 4'd6}},
		'{'{4'd4, 4'd9, 4'd15}, '{4'd4, 4'd11, 4'd13}, '{4'd8, 4'd5, 4'd15},
		  '{4'd8, 4'd7, 4'd13}, '{4'd12, 4'd5, 4'd11}, '{4'd12, 4'd7, 4'd9}},
		'{'{4'd0, 4'd9, 4'd15}, '{4'd0, 4'd11, 4'd13}, '{4'd8, 4'd1, 4'd15},
		  '{4'd8, 4'd3, 4'd13}, '{4'd12, 4'd1, 4'd11}, '{4'd12, 4'd3, 4'd9}},
		'{'{4'd0, 4'd5, 4'd15}, '{4'd0, 4'd7, 4'd13}, '{4'd4, 4'd1, 4'd15},
		  '{4'd4, 4'd3, 4'd13}, '{4'd12, 4'd1, 4'd7}, '{4'd12, 4'd3, 4'd5}},
		'{'{4'd0, 4'd5, 4'd11}, '{4'd0, 4'd7, 4'd9}, '{4'd4, 4'd1, 4'd11},
		  '{4'd4, 4'd3, 4'd9}, '{4'd8, 4'd1, 4'd7}, '{4'd8, 4'd3, 4'd5}},
		'{'{4'd4, 4'd9, 4'd14}, '{4'd4, 4'd10, 4'd13}, '{4'd8, 4'd5, 4'd14},
		  '{4'd8, 4'd6, 4'd13}, '{4'd12, 4'd5, 4'd10}, '{4'd12, 4'd6, 4'd9}},
		'{'{4'd0, 4'd9, 4'd14}, '{4'd0, 4'd10, 4'd13}, '{4'd8, 4'd1, 4'd14},
		  '{4'd8, 4'd2, 4'd13}, '{4'd12, 4'd1, 4'd10}, '{4'd12, 4'd2, 4'd9}},
		'{'{4'd0, 4'd5, 4'd14}, '{4'd0, 4'd6, 4'd13}, '{4'd4, 4'd1, 4'd14},
		  '{4'd4, 4'd2, 4'd13}, '{4'd12, 4'd1, 4'd6}, '{4'd12, 4'd2, 4'd5}},
		'{'{4'd0, 4'd5, 4'd10}, '{4'd0, 4'd6, 4'd9}, '{4'd4, 4'd1, 4'd10},
		  '{4'd4, 4'd2, 4'd9}, '{4'd8, 4'd1, 4'd6}, '{4'd8, 4'd2, 4'd5}}
	};

	typedef enum logic [4:0] {
		S_LOAD, S_FA, S_FB, S_FC, S_MUL, S_ACC, S_TACC,
		S_DA, S_DB, S_DACC, S_DFIN, S_VA, S_DIVW, S_VF, S_OUT
	} state_t;

	function automatic int div_width(input int frac_bits);
		int num_w;
		int dsh_w;
		num_w = CMAG_W + 2 * frac_bits;
		dsh_w = DMAG_W + QB - 1;
		return (num_w > dsh_w) ? num_w : dsh_w;
	endfunction

endpackage

### hdl/mx4_div.sv
// Restoring divider producing a 34-bit quotient, one bit per cycle.
module mx4_div import mx4_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [div_width(FRAC_BITS)-1:0]   num,
	input  logic [DMAG_W-1:0]                 den,
	output logic                              done,
	output logic [QB-1:0]                     quot
);

	localparam int DIV_W = div_width(FRAC_BITS);
	localparam int CNT_W = $clog2(QB);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] r_q;
	logic [DIV_W-1:0] dsh_q;
	logic [QB-1:0]    q_q;
	logic             ge;

	assign ge = (r_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num;
			dsh_q <= DIV_W'(den) << (QB - 1);
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				r_q <= r_q - dsh_q;
			end
			q_q   <= {q_q[QB-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

### hdl/matrix4_inverse_cofactor.sv
// After the sixteenth request the block forms the cofactors and determinant, then divides
// each of the sixteen results in turn with the one-bit-per-cycle divider.
// A new matrix is loaded only after the last result is taken; one request per cycle
// while loading. The cofactor and determinant products share one 32x32 multiplier.
// Reset clears the sequencer and the load slot; the element and cofactor stores are not cleared.
module matrix4_inverse_cofactor import mx4_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               element_valid,
	output logic               element_ready,
	input  logic signed [31:0] element,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] value,
	output logic [3:0]         index,
	output logic               last,
	output logic               singular,
	output logic               saturated
);

	localparam int DIV_W = div_width(FRAC_BITS);

	state_t state_q, state_d, ret_q;
	logic [3:0]  cnt_q, e_q, k_q;
	logic [2:0]  t_q;
	logic [1:0]  j_q, limb_q, nlimb_q;

	logic [EL_W-1:0]   mem_q [16];
	logic [COF_W-1:0]  cof_q [16];
	logic [DET_W-1:0]  det_q;
	logic [DMAG_W-1:0] dmag_q;
	logic              sing_q, dneg_q, nneg_q, neg_q;
	logic [CMAG_W-1:0] x_q;
	logic [EL_W-1:0]   m_q;
	logic [PMAG_W-1:0] y_q;
	logic [63:0]       pr_s1;

	logic [31:0] value_q;
	logic [3:0]  index_q;
	logic        last_q, sing_out_q, sat_q;

	logic [3:0]        ridx, cidx;
	logic [EL_W-1:0]   mem_rd, mem_neg, mem_mag;
	logic [COF_W-1:0]  cof_rd, cof_neg, cof_term;
	logic [CMAG_W-1:0] cmag;
	logic [DET_W-1:0]  det_neg, det_term;
	logic [31:0]       x_limb;
	logic [PMAG_W-1:0] addend;
	logic [DIV_W-1:0]  num;
	logic              div_start, div_done;
	logic [QB-1:0]     quot;
	logic              in_acc, out_acc;
	logic              v_pos, v_sat;
	logic [31:0]       v_val;

	assign in_acc  = element_valid && element_ready;
	assign out_acc = result_valid && result_ready;

	always_comb begin
		case (state_q)
			S_FA:    ridx = TERMS[e_q][t_q][0];
			S_FB:    ridx = TERMS[e_q][t_q][1];
			S_FC:    ridx = TERMS[e_q][t_q][2];
			S_DB:    ridx = {2'b00, j_q};
			default: ridx = 4'd0;
		endcase
		case (state_q)
			S_DA:    cidx = {j_q, 2'b00};
			S_VA:    cidx = k_q;
			default: cidx = e_q;
		endcase
	end

	assign mem_rd  = mem_q[ridx];
	assign mem_neg = -mem_rd;
	assign mem_mag = mem_rd[EL_W-1] ? mem_neg : mem_rd;

	assign cof_rd  = cof_q[cidx];
	assign cof_neg = -cof_rd;
	assign cmag    = cof_rd[COF_W-1] ? cof_neg[CMAG_W-1:0] : cof_rd[CMAG_W-1:0];
	assign cof_term = neg_q ? -COF_W'(y_q[CMAG_W-1:0]) : COF_W'(y_q[CMAG_W-1:0]);

	assign det_neg  = -det_q;
	assign det_term = neg_q ? -DET_W'(y_q) : DET_W'(y_q);

	assign num = DIV_W'(cmag) << (2 * FRAC_BITS);

	always_comb begin
		case (limb_q)
			2'd0:    x_limb = x_q[31:0];
			2'd1:    x_limb = x_q[63:32];
			default: x_limb = x_q[95:64];
		endcase
		case (limb_q)
			2'd0:    addend = PMAG_W'(pr_s1);
			2'd1:    addend = PMAG_W'(pr_s1) << 32;
			default: addend = PMAG_W'(pr_s1) << 64;
		endcase
	end

	always_comb begin
		v_pos = !(nneg_q ^ dneg_q);
		if (v_pos) begin
			v_sat = (quot[QB-1:31] != '0);
			v_val = v_sat ? 32'h7FFF_FFFF : quot[31:0];
		end else begin
			v_sat = (quot[QB-1:32] != '0) || (quot[31:0] > 32'h8000_0000);
			v_val = v_sat ? 32'h8000_0000 : -quot[31:0];
		end
	end

	always_comb begin
		state_d       = state_q;
		element_ready = 1'b0;
		result_valid  = 1'b0;
		div_start     = 1'b0;
		case (state_q)
			S_LOAD: begin
				element_ready = 1'b1;
				if (element_valid && cnt_q == 4'd15) begin
					state_d = S_FA;
				end
			end
			S_FA:  state_d = S_FB;
			S_FB:  state_d = S_MUL;
			S_FC:  state_d = S_MUL;
			S_MUL: state_d = S_ACC;
			S_ACC: state_d = (limb_q == nlimb_q) ? ret_q : S_MUL;
			S_TACC: state_d = (t_q == 3'd5 && e_q == 4'd15) ? S_DA : S_FA;
			S_DA:  state_d = S_DB;
			S_DB:  state_d = S_MUL;
			S_DACC: state_d = (j_q == 2'd3) ? S_DFIN : S_DA;
			S_DFIN: state_d = S_VA;
			S_VA: begin
				div_start = !sing_q;
				state_d   = sing_q ? S_VF : S_DIVW;
			end
			S_DIVW: begin
				if (div_done) begin
					state_d = S_VF;
				end
			end
			S_VF: state_d = S_OUT;
			S_OUT: begin
				result_valid = 1'b1;
				if (result_ready) begin
					state_d = (k_q == 4'd15) ? S_LOAD : S_VA;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ret_q   <= S_LOAD;
			cnt_q   <= '0;
			e_q     <= '0;
			t_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			limb_q  <= '0;
			nlimb_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_q + 1'b1;
						e_q   <= '0;
						t_q   <= '0;
					end
				end
				S_FB: begin
					limb_q  <= '0;
					nlimb_q <= 2'd0;
					ret_q   <= S_FC;
				end
				S_FC: begin
					limb_q  <= '0;
					nlimb_q <= 2'd1;
					ret_q   <= S_TACC;
				end
				S_DB: begin
					limb_q  <= '0;
					nlimb_q <= 2'd2;
					ret_q   <= S_DACC;
				end
				S_ACC: limb_q <= limb_q + 1'b1;
				S_TACC: begin
					j_q <= '0;
					if (t_q == 3'd5) begin
						t_q <= '0;
						e_q <= e_q + 1'b1;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_DACC: j_q <= j_q + 1'b1;
				S_DFIN: k_q <= '0;
				S_OUT: begin
					if (out_acc) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				if (in_acc) begin
					mem_q[cnt_q] <= element;
				end
			end
			S_FA: begin
				x_q   <= CMAG_W'(mem_mag);
				neg_q <= mem_rd[EL_W-1] ^ BASE_SIGN[t_q] ^ ROW_FLIP[e_q];
			end
			S_FB, S_DB: begin
				m_q   <= mem_mag;
				neg_q <= neg_q ^ mem_rd[EL_W-1];
				y_q   <= '0;
			end
			S_FC: begin
				x_q   <= y_q[CMAG_W-1:0];
				m_q   <= mem_mag;
				neg_q <= neg_q ^ mem_rd[EL_W-1];
				y_q   <= '0;
			end
			S_MUL: pr_s1 <= x_limb * m_q;
			S_ACC: y_q <= y_q + addend;
			S_TACC: cof_q[e_q] <= ((t_q == 3'd0) ? '0 : cof_rd) + cof_term;
			S_DA: begin
				x_q   <= cmag;
				neg_q <= cof_rd[COF_W-1];
			end
			S_DACC: det_q <= ((j_q == 2'd0) ? '0 : det_q) + det_term;
			S_DFIN: begin
				dmag_q <= det_q[DET_W-1] ? det_neg[DMAG_W-1:0] : det_q[DMAG_W-1:0];
				sing_q <= (det_q == '0);
				dneg_q <= det_q[DET_W-1];
			end
			S_VA: nneg_q <= cof_rd[COF_W-1];
			S_VF: begin
				value_q    <= sing_q ? 32'd0 : v_val;
				sat_q      <= sing_q ? 1'b0 : v_sat;
				sing_out_q <= sing_q;
				index_q    <= k_q;
				last_q     <= (k_q == 4'd15);
			end
			default: ;
		endcase
	end

	mx4_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (dmag_q),
		.done   (div_done),
		.quot   (quot)
	);

	assign value     = value_q;
	assign index     = index_q;
	assign last      = last_q;
	assign singular  = sing_out_q;
	assign saturated = sat_q;

endmodule

### tb/matrix4_inverse_cofactor_tb.sv
// Self-checking testbench for the 4x4 cofactor matrix inverter with an exact predictor.
module matrix4_inverse_cofactor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic [31:0] word;
		bit          drain_first;
	} load_req_t;

	typedef struct {
		logic signed [31:0] value;
		logic [3:0]         index;
		logic               last;
		logic               singular;
		logic               saturated;
	} inv_elem_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               element_valid = 1'b0;
	logic               element_ready;
	logic signed [31:0] element = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [31:0] value;
	logic [3:0]         index;
	logic               last;
	logic               singular;
	logic               saturated;

	load_req_t   pending_loads[$];
	inv_elem_t   inverse_due[$];
	logic [31:0] mat_shadow[16];
	int          slot = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          recv_hold = 0;
	bit          hold_done = 0;
	bit          quiet = 0;
	int          n_accepted = 0;
	int          n_matrices = 0;
	int          n_singular = 0;
	int          n_sat = 0;
	int          n_results = 0;
	int          n_errors = 0;

	matrix4_inverse_cofactor u_top (
		.clk(clk), .arst_n(arst_n),
		.element_valid(element_valid), .element_ready(element_ready), .element(element),
		.result_valid(result_valid), .result_ready(result_ready),
		.value(value), .index(index), .last(last), .singular(singular),
		.saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic wide_t minor_det(input int skip_r, input int skip_c);
		int    rr[3];
		int    cc[3];
		int    n;
		wide_t e[3][3];
		n = 0;
		for (int r = 0; r < 4; r++) if (r != skip_r) begin rr[n] = r; n++; end
		n = 0;
		for (int c = 0; c < 4; c++) if (c != skip_c) begin cc[n] = c; n++; end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				e[i][j] = $signed(mat_shadow[rr[i] * 4 + cc[j]]);
		return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
			- e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
			+ e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
	endfunction

	task automatic predict_inverse();
		wide_t     adj[16];
		wide_t     det;
		wide_t     quo;
		inv_elem_t r;
		det = '0;
		for (int k = 0; k < 16; k++) begin
			adj[k] = minor_det(k % 4, k / 4);
			if (((k / 4) + (k % 4)) % 2) adj[k] = -adj[k];
		end
		for (int j = 0; j < 4; j++) det += wide_t'($signed(mat_shadow[j])) * adj[4 * j];
		n_matrices++;
		if (det == 0) n_singular++;
		for (int k = 0; k < 16; k++) begin
			r.index = k[3:0];
			r.last = (k == 15);
			r.singular = (det == 0);
			r.saturated = 1'b0;
			r.value = '0;
			if (det != 0) begin
				quo = (adj[k] <<< 32) / det;
				if (quo > wide_t'(64'sh7FFFFFFF)) begin
					r.value = 32'h7FFFFFFF;
					r.saturated = 1'b1;
				end else if (quo < -wide_t'(64'sh80000000)) begin
					r.value = 32'h80000000;
					r.saturated = 1'b1;
				end else begin
					r.value = quo[31:0];
				end
			end
			if (r.saturated) n_sat++;
			inverse_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_valid <= 1'b0;
		end else begin
			if (element_valid && element_ready) begin
				mat_shadow[slot] = element;
				slot = (slot + 1) % 16;
				n_accepted++;
				if (slot == 0) predict_inverse();
			end
			if (!element_valid || element_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					element_valid <= 1'b0;
				end else if (pending_loads.size() > 0 &&
						!(pending_loads[0].drain_first && inverse_due.size() > 0)) begin
					element <= pending_loads[0].word;
					pending_loads[0].drain_first = 0;
					void'(pending_loads.pop_front());
					element_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 7);
				end else begin
					element_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				n_results++;
				if (inverse_due.size() == 0) begin
					$error("unexpected result index %0d value %0d", index, value);
					n_errors++;
				end else begin
					if (value !== inverse_due[0].value) begin
						$error("value: expected %0d, got %0d", inverse_due[0].value, value);
						n_errors++;
					end
					if (index !== inverse_due[0].index) begin
						$error("index: expected %0d, got %0d", inverse_due[0].index, index);
						n_errors++;
					end
					if (last !== inverse_due[0].last) begin
						$error("last: expected %0b, got %0b", inverse_due[0].last, last);
						n_errors++;
					end
					if (singular !== inverse_due[0].singular) begin
						$error("singular: expected %0b, got %0b", inverse_due[0].singular,
							singular);
						n_errors++;
					end
					if (saturated !== inverse_due[0].saturated) begin
						$error("saturated: expected %0b, got %0b", inverse_due[0].saturated,
							saturated);
						n_errors++;
					end
					void'(inverse_due.pop_front());
				end
			end
			if (!hold_done && n_accepted >= 100) begin
				hold_done = 1;
				recv_hold = 4000;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				result_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 7);
			end
		end
	end

	task automatic queue_matrix(input logic [31:0] m[16], input bit drain);
		load_req_t q;
		for (int i = 0; i < 16; i++) begin
			q.word = m[i];
			q.drain_first = drain && (i == 0);
			pending_loads.push_back(q);
		end
	endtask

	initial begin
		logic [31:0] m[16];
		int          kind;
		int          total;
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'hFFFFFFFE : 32'h0;
		queue_matrix(m, 0);
		for (int i = 0; i < 16; i++) m[i] = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
		m[4] = 32'h80000000;
		m[5] = 32'h7FFFFFFF;
		queue_matrix(m, 0);
		for (int n = 0; n < 24; n++) begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 16; i++) begin
				case (kind)
					0, 1, 2: m[i] = $urandom;
					3, 4:    m[i] = $urandom_range(0, 6 * 65536) - 3 * 65536;
					default: m[i] = ((i % 5 == 0) ? 32'sd65536 * $urandom_range(1, 4) : 0)
						+ $urandom_range(0, 32768) - 16384;
				endcase
			end
			if (kind == 9) for (int c = 0; c < 4; c++) m[12 + c] = m[4 + c];
			queue_matrix(m, n == 10);
		end
		total = pending_loads.size();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_loads.size() > 0 || element_valid) begin
			@(posedge clk);
			if (pending_loads.size() < total / 8) quiet = 1;
		end
		while (inverse_due.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d matrices (%0d requests): %0d singular, %0d saturated results.",
			n_matrices, n_accepted, n_singular, n_sat);
		$display("%0d results checked, %0d mismatches.", n_results, n_errors);
		if (n_errors == 0 && inverse_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

### sim.f
hdl/mx4_pkg.sv
hdl/mx4_div.sv
hdl/matrix4_inverse_cofactor.sv
tb/matrix4_inverse_cofactor_tb.sv
